// File: hdl/fba_pkg.sv
// shared types and constants for the first-fit block allocator
`default_nettype none

package fba_pkg;

   localparam int MAX_BLOCKS_DEF = 16;

   localparam int ID_W   = 8;
   localparam int SIZE_W = 16;
   localparam int PROC_W = 16;
   localparam int STAT_W = 2;

   // request kinds
   localparam logic REQ_LOAD  = 1'b0;
   localparam logic REQ_ALLOC = 1'b1;

   // result status codes
   localparam logic [STAT_W-1:0] ST_LOADED    = 2'd0;
   localparam logic [STAT_W-1:0] ST_ALLOCATED = 2'd1;
   localparam logic [STAT_W-1:0] ST_NOFIT     = 2'd2;
   localparam logic [STAT_W-1:0] ST_FULL      = 2'd3;

   typedef struct packed {
      logic [ID_W-1:0]   id;
      logic [SIZE_W-1:0] size;
   } entry_type;

   typedef struct packed {
      logic [STAT_W-1:0] status;
      logic [ID_W-1:0]   grant;
      logic [SIZE_W-1:0] frag;
   } result_type;

endpackage

`default_nettype wire

// File: hdl/fba_table.sv
// block table: id/size memory with registered read plus allocated flags
`default_nettype none

module fba_table #(
   parameter int MAX_BLOCKS = fba_pkg::MAX_BLOCKS_DEF,
   parameter int IDX_W      = $clog2(MAX_BLOCKS)
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               wr_en,
   input  wire logic [IDX_W-1:0]   wr_addr,
   input  wire fba_pkg::entry_type wr_entry,
   input  wire logic [IDX_W-1:0]   rd_addr,
   output fba_pkg::entry_type      rd_entry,
   output logic                    rd_taken,
   input  wire logic               set_en,
   input  wire logic [IDX_W-1:0]   set_addr
);

   fba_pkg::entry_type mem [MAX_BLOCKS];
   fba_pkg::entry_type rd_entry_ff;
   logic [MAX_BLOCKS-1:0] taken_ff;
   logic [MAX_BLOCKS-1:0] taken_in;
   logic                  rd_taken_ff;

   // entry memory, no reset: the scan only acts on loaded entries
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_entry;
      end
      rd_entry_ff <= mem[rd_addr];
   end

   always_comb begin
      taken_in = taken_ff;
      if (wr_en) begin
         taken_in[wr_addr] = 1'b0;
      end
      if (set_en) begin
         taken_in[set_addr] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         taken_ff    <= '0;
         rd_taken_ff <= 1'b0;
      end else begin
         taken_ff    <= taken_in;
         rd_taken_ff <= taken_ff[rd_addr];
      end
   end

   assign rd_entry = rd_entry_ff;
   assign rd_taken = rd_taken_ff;

endmodule

`default_nettype wire

// File: hdl/first_fit_block_allocator_core.sv
// top level of the first-fit block allocator: sequencer, scan and result register
//
//   channel | ports                                    | dir | handshake
//   --------+------------------------------------------+-----+---------------------
//   request | req_type req_block_id req_size           | in  | req_valid / req_stall
//           | req_process_id                           |     |
//   result  | rsp_status rsp_echo_process              | out | rsp_valid / rsp_stall
//           | rsp_granted_block rsp_fragment           |     |
//
// a load word writes the table on accept (unless it is full), then is handed off
// from S_DONE into the output register; an allocate word scans the entries from
// 0 in order until a hit or the last entry, with the table memory read one entry
// per cycle through a registered read; one word is worked on at a time; req_stall
// is high from accept until the result has moved into the output register, which
// can hold a word while rsp_stall is high; the next word is taken the cycle after
// the hand-off; reset clears the sequencer state, the entry count, the allocated
// flags and the result valid flag; the table contents are not cleared and there
// is no clearing pass
`default_nettype none

module first_fit_block_allocator_core #(
   parameter int MAX_BLOCKS = fba_pkg::MAX_BLOCKS_DEF
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   // request channel
   input  wire logic                         req_valid,
   output logic                              req_stall,
   input  wire logic                         req_type,
   input  wire logic [fba_pkg::ID_W-1:0]     req_block_id,
   input  wire logic [fba_pkg::SIZE_W-1:0]   req_size,
   input  wire logic [fba_pkg::PROC_W-1:0]   req_process_id,
   // result channel
   output logic                              rsp_valid,
   input  wire logic                         rsp_stall,
   output logic [fba_pkg::STAT_W-1:0]        rsp_status,
   output logic [fba_pkg::PROC_W-1:0]        rsp_echo_process,
   output logic [fba_pkg::ID_W-1:0]          rsp_granted_block,
   output logic [fba_pkg::SIZE_W-1:0]        rsp_fragment
);

   localparam int IDX_W = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
   localparam int CNT_W = $clog2(MAX_BLOCKS + 1);

   // sequencer states
   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_SCAN = 2'd1;
   localparam logic [1:0] S_DONE = 2'd2;

   logic [1:0]                     state_ff, state_in;
   logic [CNT_W-1:0]               count_ff, count_in;
   logic [IDX_W-1:0]               idx_ff, idx_in;
   logic [fba_pkg::SIZE_W-1:0]     amt_ff, amt_in;
   logic [fba_pkg::PROC_W-1:0]     proc_ff, proc_in;
   fba_pkg::result_type            res_ff, res_in;

   // output register
   logic                           rsp_valid_ff, rsp_valid_in;
   fba_pkg::result_type            out_ff, out_in;
   logic [fba_pkg::PROC_W-1:0]     out_proc_ff, out_proc_in;

   // table interface
   logic                           wr_en;
   fba_pkg::entry_type             wr_entry;
   logic [IDX_W-1:0]               rd_addr;
   fba_pkg::entry_type             rd_entry;
   logic                           rd_taken;
   logic                           set_en;

   logic req_accept;
   logic out_free;
   logic last_entry;

   fba_table #(
      .MAX_BLOCKS (MAX_BLOCKS),
      .IDX_W      (IDX_W)
   ) u_table (
      .clock    (clock),
      .reset    (reset),
      .wr_en    (wr_en),
      .wr_addr  (count_ff[IDX_W-1:0]),
      .wr_entry (wr_entry),
      .rd_addr  (rd_addr),
      .rd_entry (rd_entry),
      .rd_taken (rd_taken),
      .set_en   (set_en),
      .set_addr (idx_ff)
   );

   assign req_stall  = (state_ff != S_IDLE);
   assign req_accept = req_valid && !req_stall;
   assign out_free   = !rsp_valid_ff || !rsp_stall;
   assign last_entry = ((CNT_W'(idx_ff) + CNT_W'(1)) == count_ff);

   // the scan always prefetches the entry after the one being checked
   assign rd_addr = (state_ff == S_IDLE) ? '0 : idx_ff + IDX_W'(1);

   assign wr_entry.id   = req_block_id;
   assign wr_entry.size = req_size;

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      idx_in       = idx_ff;
      amt_in       = amt_ff;
      proc_in      = proc_ff;
      res_in       = res_ff;
      wr_en        = 1'b0;
      set_en       = 1'b0;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      out_in       = out_ff;
      out_proc_in  = out_proc_ff;

      case (state_ff)
         S_IDLE: begin
            if (req_accept) begin
               proc_in = req_process_id;
               amt_in  = req_size;
               idx_in  = '0;
               res_in  = '{status: fba_pkg::ST_NOFIT, grant: '0, frag: '0};
               if (req_type == fba_pkg::REQ_LOAD) begin
                  state_in = S_DONE;
                  if (count_ff == CNT_W'(MAX_BLOCKS)) begin
                     res_in.status = fba_pkg::ST_FULL;
                  end else begin
                     wr_en         = 1'b1;
                     count_in      = count_ff + CNT_W'(1);
                     res_in.status = fba_pkg::ST_LOADED;
                  end
               end else if (count_ff == '0) begin
                  // empty table, nothing to scan
                  state_in = S_DONE;
               end else begin
                  state_in = S_SCAN;
               end
            end
         end
         S_SCAN: begin
            // first free entry that is large enough wins
            if (!rd_taken && (rd_entry.size >= amt_ff)) begin
               set_en   = 1'b1;
               res_in   = '{status: fba_pkg::ST_ALLOCATED,
                            grant:  rd_entry.id,
                            frag:   rd_entry.size - amt_ff};
               state_in = S_DONE;
            end else if (last_entry) begin
               state_in = S_DONE;
            end else begin
               idx_in = idx_ff + IDX_W'(1);
            end
         end
         S_DONE: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               out_in       = res_ff;
               out_proc_in  = proc_ff;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      idx_ff      <= idx_in;
      amt_ff      <= amt_in;
      proc_ff     <= proc_in;
      res_ff      <= res_in;
      out_ff      <= out_in;
      out_proc_ff <= out_proc_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_status        = out_ff.status;
   assign rsp_echo_process  = out_proc_ff;
   assign rsp_granted_block = out_ff.grant;
   assign rsp_fragment      = out_ff.frag;

endmodule

`default_nettype wire
